/* rtl/core/osr_pkg.sv */
// Package for the OLED sprite refresh sequencer: payload and microcode types,
// panel constants, bus byte codes, boot command and sprite tables.
// No dependencies; imported by every module of the block.
`default_nettype none

package osr_pkg;

    // Panel and sequencing constants
    localparam int INIT_LENGTH      = 24;
    localparam int PANEL_COLUMNS    = 128;
    localparam int PANEL_PAGES      = 8;
    localparam int COLUMNS_PER_CALL = 16;

    localparam int BOOT_LEN    = 24;
    localparam int SPRITE_W    = 64;
    localparam int SPRITE_LEFT = (PANEL_COLUMNS - SPRITE_W) / 2;
    localparam int GLYPH_COUNT = 12;
    localparam int TEST_FACE   = 12;

    localparam int COL_W  = $clog2(PANEL_COLUMNS + 1);
    localparam int PAGE_W = $clog2(PANEL_PAGES);
    localparam int CNT_W  = $clog2(COLUMNS_PER_CALL + 1);
    localparam int INIT_W = 5;
    localparam int STEP_W = 5;

    // Input operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POWER_DELAY  = 1'b0;
    localparam logic CFG_INITIAL_FACE = 1'b1;

    localparam logic [15:0] POWER_DELAY_RESET = 16'd200;
    localparam logic [7:0]  INITIAL_FACE_RESET = 8'd0;
    localparam logic [7:0]  FACE_NONE = 8'hFF;

    // Bus byte codes
    localparam logic [7:0] BUS_ADDR   = 8'h78;
    localparam logic [7:0] CTRL_CMD   = 8'h00;
    localparam logic [7:0] CTRL_DATA  = 8'h40;
    localparam logic [7:0] CMD_ON     = 8'hAF;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_NOP    = 8'hE3;

    // Payload types
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] face;
    } osr_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } osr_result_t;

    // Microcode fields
    typedef enum logic [1:0] {
        BYTE_CONST,
        BYTE_INIT,
        BYTE_PAGE,
        BYTE_PIXEL
    } byte_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_PIXEL
    } last_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT_ADV,
        ACT_DRAW_START,
        ACT_CHUNK_SETUP,
        ACT_COL_ADV,
        ACT_PAGE_ADV
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_PANEL_READY,
        COND_SETTLED,
        COND_INIT_NONZERO,
        COND_DRAW_NEEDED,
        COND_COL_NONZERO,
        COND_CHUNK_MORE,
        COND_FRAME_END
    } cond_t;

    typedef struct packed {
        logic              emit;
        logic              kind;
        byte_sel_t         bsel;
        logic [7:0]        konst;
        logic              start;
        logic              stop;
        last_sel_t         lsel;
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              done;
    } uword_t;

    // Sequencer to datapath strobes
    typedef struct packed {
        logic   accept;
        logic   fire;
        uword_t uw;
    } seq_ctrl_t;

    // Datapath to sequencer branch conditions
    typedef struct packed {
        logic panel_ready;
        logic settled;
        logic init_nonzero;
        logic draw_needed;
        logic col_nonzero;
        logic chunk_end;
        logic frame_end;
        logic slot_free;
    } dp_status_t;

    // Panel init command list
    localparam logic [7:0] BOOT_TABLE [BOOT_LEN] = '{
        8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
        8'h8D, 8'h14, 8'h20, 8'h02, 8'hA1, 8'hC8, 8'hDA, 8'h12,
        8'h81, 8'h7F, 8'hD9, 8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6
    };

    // 16x16 faces, one word per row, MSB is the leftmost pixel
    localparam logic [15:0] GLYPHS [GLYPH_COUNT][16] = '{
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'h9999,16'h8181,
          16'h8001,16'h8421,16'h83C1,16'h8001,16'hC003,16'h6006,16'h3FFC,16'h0000},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'hA5A5,16'h9999,
          16'h8001,16'h8181,16'h8241,16'h8421,16'hC183,16'h6006,16'h3FFC,16'h0000},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'h9DB9,16'hA5A5,
          16'h8001,16'h8181,16'h8241,16'h8241,16'hC183,16'h6006,16'h3FFC,16'h0000},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'hA5A5,16'h9999,
          16'h8001,16'h9249,16'h8921,16'h9249,16'hC003,16'h6006,16'h3FFC,16'h0000},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'h8001,16'h9FF9,
          16'h8001,16'h8181,16'h83C1,16'h8001,16'hC003,16'h6006,16'h3FFC,16'h0000},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8001,16'h9999,16'h8181,
          16'h8421,16'h8241,16'h8181,16'h8421,16'hC003,16'h6006,16'h3FFC,16'h0240},
        '{16'h0810,16'h1C38,16'h366C,16'h63C6,16'hC003,16'h8101,16'h9989,16'h8181,
          16'h8001,16'h8241,16'h8421,16'h8001,16'hC403,16'h6606,16'h3FFC,16'h0C18},
        '{16'h0180,16'h03C0,16'h07E0,16'h0DB0,16'h1980,16'h3180,16'h6180,16'hFFFF,
          16'hFFFF,16'h6180,16'h3180,16'h1980,16'h0DB0,16'h07E0,16'h03C0,16'h0180},
        '{16'h0180,16'h03C0,16'h07E0,16'h0DB0,16'h0180,16'h0180,16'h0180,16'hFFFF,
          16'hFFFF,16'h6186,16'h318C,16'h1998,16'h0DB0,16'h07E0,16'h03C0,16'h0180},
        '{16'h0180,16'h0380,16'h0780,16'h0FFF,16'h1FFF,16'h3FFF,16'h7FFF,16'hFFFF,
          16'hFFFF,16'h7FFF,16'h3FFF,16'h1FFF,16'h0FFF,16'h0780,16'h0380,16'h0180},
        '{16'h0180,16'h01C0,16'h01E0,16'hFFF0,16'hFFF8,16'hFFFC,16'hFFFE,16'hFFFF,
          16'hFFFF,16'hFFFE,16'hFFFC,16'hFFF8,16'hFFF0,16'h01E0,16'h01C0,16'h0180},
        '{16'h8001,16'hC003,16'h6006,16'h300C,16'h1818,16'h0C30,16'h0660,16'h03C0,
          16'h03C0,16'h0660,16'h0C30,16'h1818,16'h300C,16'h6006,16'hC003,16'h8001}
    };

    // Init command for a step; steps past the list send a no-op
    function automatic logic [7:0] boot_cmd(input logic [INIT_W-1:0] idx);
        logic [7:0] v;
        v = CMD_NOP;
        if (idx < INIT_W'(BOOT_LEN)) begin
            v = BOOT_TABLE[idx];
        end
        return v;
    endfunction

    // One column byte of a face: 4x scaled sprite, test pattern or blank
    function automatic logic [7:0] column_byte(input logic [7:0] f,
                                               input logic [COL_W-1:0] x,
                                               input logic [PAGE_W-1:0] pg);
        logic [COL_W-1:0] rel;
        logic [3:0]       sh;
        logic [3:0]       row0;
        logic [3:0]       row1;
        logic [3:0]       fi;
        logic [15:0]      mask;
        logic [7:0]       v;
        v    = 8'h00;
        rel  = x - COL_W'(SPRITE_LEFT);
        sh   = rel[5:2];
        mask = 16'h8000 >> sh;
        row0 = {3'(pg), 1'b0};
        row1 = {3'(pg), 1'b1};
        fi   = (f < 8'(GLYPH_COUNT)) ? f[3:0] : 4'd0;
        if (f == 8'(TEST_FACE)) begin
            if (x == '0 || x == COL_W'(PANEL_COLUMNS - 1)) begin
                v = 8'hFF;
            end else if (pg == '0) begin
                v = 8'h01;
            end else if (pg == PAGE_W'(PANEL_PAGES - 1)) begin
                v = 8'h80;
            end else begin
                v = x[3] ? 8'hAA : 8'h55;
            end
        end else if (f < 8'(GLYPH_COUNT) && x >= COL_W'(SPRITE_LEFT)
                     && x < COL_W'(SPRITE_LEFT + SPRITE_W)) begin
            if ((GLYPHS[fi][row0] & mask) != 16'h0000) begin
                v = 8'h0F;
            end
            if ((GLYPHS[fi][row1] & mask) != 16'h0000) begin
                v = v | 8'hF0;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/oled_sprite_refresh_sequencer.sv */
// Top level of the OLED sprite refresh sequencer: control store, step counter
// and datapath. Depends on osr_pkg, osr_ucode_rom, osr_sequencer, osr_datapath.
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------
// item     | item_valid / item_ready    | osr_item_t   (op, face)
// result   | result_valid / result_ready| osr_result_t (kind .. last)
// config   | cfg_we                     | cfg_index, cfg_data[15:0]
//
// Face requests, ticks and unused ops are taken with no result. A service call
// runs the microprogram at one step a cycle while the result slot is free: an
// init call sends one command, the first one after a bus recovery result; a draw
// call runs one step per result plus five branch steps, with page position before
// each page and display-on after the last. The next request is taken in the cycle after the last step.
// A result waiting in the output register holds the emitting step until taken.
// Reset is asynchronous; there is no clearing pass.
`default_nettype none

module oled_sprite_refresh_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire osr_pkg::osr_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output osr_pkg::osr_result_t     result,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import osr_pkg::*;

    logic [STEP_W-1:0] pc;
    uword_t            uw;
    seq_ctrl_t         ctrl;
    dp_status_t        st;

    osr_ucode_rom u_rom (
        .addr (pc),
        .uw   (uw)
    );

    osr_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .uw         (uw),
        .st         (st),
        .pc         (pc),
        .ctrl       (ctrl)
    );

    osr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .ctrl         (ctrl),
        .st           (st),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/core/osr_ucode_rom.sv */
// Control store of the refresh sequencer: one control word per program step.
// Depends on osr_pkg for the control word type and bus byte codes.
`default_nettype none

module osr_ucode_rom (
    input  wire logic [osr_pkg::STEP_W-1:0] addr,
    output osr_pkg::uword_t                 uw
);
    import osr_pkg::*;

    // Jump targets
    localparam logic [STEP_W-1:0] ST_CMD    = 5'd4;
    localparam logic [STEP_W-1:0] ST_DRAW   = 5'd7;
    localparam logic [STEP_W-1:0] ST_PREP   = 5'd8;
    localparam logic [STEP_W-1:0] ST_DATA   = 5'd19;
    localparam logic [STEP_W-1:0] ST_PIXEL  = 5'd21;
    localparam logic [STEP_W-1:0] ST_ON     = 5'd23;
    localparam logic [STEP_W-1:0] ST_SETTLE = 5'd2;
    localparam logic [STEP_W-1:0] ST_NONE   = 5'd0;

    function automatic uword_t mk(input logic              emit,
                                  input logic              kind,
                                  input byte_sel_t         bsel,
                                  input logic [7:0]        konst,
                                  input logic              start,
                                  input logic              stop,
                                  input last_sel_t         lsel,
                                  input act_t              act,
                                  input cond_t             cond,
                                  input logic [STEP_W-1:0] target,
                                  input logic              done);
        uword_t w;
        w.emit   = emit;
        w.kind   = kind;
        w.bsel   = bsel;
        w.konst  = konst;
        w.start  = start;
        w.stop   = stop;
        w.lsel   = lsel;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        w.done   = done;
        return w;
    endfunction

    // Program: init branch at step 0, draw branch from step 7
    always_comb
    begin
        case (addr)
            // dispatch and init
            5'd0:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_PANEL_READY, ST_DRAW, 1'b0);
            5'd1:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_SETTLED, ST_SETTLE, 1'b1);
            5'd2:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_INIT_NONZERO, ST_CMD, 1'b0);
            5'd3:  uw = mk(1'b1, 1'b1, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd4:  uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd5:  uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_CMD, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd6:  uw = mk(1'b1, 1'b0, BYTE_INIT, 8'h00, 1'b0, 1'b1, LAST_YES,
                           ACT_INIT_ADV, COND_NEVER, ST_NONE, 1'b1);
            // draw: skip when the face is already shown
            5'd7:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_DRAW_NEEDED, ST_PREP, 1'b1);
            5'd8:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_DRAW_START, COND_NEVER, ST_NONE, 1'b0);
            5'd9:  uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_COL_NONZERO, ST_DATA, 1'b0);
            // page position commands
            5'd10: uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd11: uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_CMD, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd12: uw = mk(1'b1, 1'b0, BYTE_PAGE, 8'h00, 1'b0, 1'b1, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd13: uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd14: uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_CMD, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd15: uw = mk(1'b1, 1'b0, BYTE_CONST, CMD_COL_LO, 1'b0, 1'b1, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd16: uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd17: uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_CMD, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd18: uw = mk(1'b1, 1'b0, BYTE_CONST, CMD_COL_HI, 1'b0, 1'b1, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            // data transfer, pixel loop on step 21
            5'd19: uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_CHUNK_SETUP, COND_NEVER, ST_NONE, 1'b0);
            5'd20: uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_DATA, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd21: uw = mk(1'b1, 1'b0, BYTE_PIXEL, 8'h00, 1'b0, 1'b0, LAST_PIXEL,
                           ACT_COL_ADV, COND_CHUNK_MORE, ST_PIXEL, 1'b0);
            5'd22: uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                           ACT_PAGE_ADV, COND_FRAME_END, ST_ON, 1'b1);
            // display on after the last page
            5'd23: uw = mk(1'b1, 1'b0, BYTE_CONST, BUS_ADDR, 1'b1, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd24: uw = mk(1'b1, 1'b0, BYTE_CONST, CTRL_CMD, 1'b0, 1'b0, LAST_NO,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b0);
            5'd25: uw = mk(1'b1, 1'b0, BYTE_CONST, CMD_ON, 1'b0, 1'b1, LAST_YES,
                           ACT_NONE, COND_NEVER, ST_NONE, 1'b1);
            default: uw = mk(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, 1'b0, LAST_NO,
                             ACT_NONE, COND_NEVER, ST_NONE, 1'b1);
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/osr_sequencer.sv */
// Step counter of the refresh sequencer: request intake, jump evaluation
// and step strobes. Depends on osr_pkg; fed by osr_ucode_rom and osr_datapath.
`default_nettype none

module osr_sequencer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire osr_pkg::osr_item_t         item,
    input  wire osr_pkg::uword_t            uw,
    input  wire osr_pkg::dp_status_t        st,
    output logic [osr_pkg::STEP_W-1:0]      pc,
    output osr_pkg::seq_ctrl_t              ctrl
);
    import osr_pkg::*;

    logic              running_reg;
    logic              running_next;
    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              accept;
    logic              step_go;
    logic              cond_true;

    assign item_ready = !running_reg;
    assign accept     = item_valid && item_ready;
    assign pc         = pc_reg;

    // An emitting step waits for a free result slot
    assign step_go = running_reg && (!uw.emit || st.slot_free);

    // Branch condition select
    always_comb
    begin
        case (uw.cond)
            COND_NEVER:        cond_true = 1'b0;
            COND_PANEL_READY:  cond_true = st.panel_ready;
            COND_SETTLED:      cond_true = st.settled;
            COND_INIT_NONZERO: cond_true = st.init_nonzero;
            COND_DRAW_NEEDED:  cond_true = st.draw_needed;
            COND_COL_NONZERO:  cond_true = st.col_nonzero;
            COND_CHUNK_MORE:   cond_true = !st.chunk_end;
            COND_FRAME_END:    cond_true = st.frame_end;
            default:           cond_true = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        running_next = running_reg;
        pc_next      = pc_reg;
        if (accept && item.op == OP_SERVICE) begin
            running_next = 1'b1;
            pc_next      = '0;
        end else if (step_go) begin
            if (cond_true) begin
                pc_next = uw.target;
            end else if (uw.done) begin
                running_next = 1'b0;
            end else begin
                pc_next = pc_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            running_reg <= running_next;
            pc_reg      <= pc_next;
        end
    end

    assign ctrl.accept = accept;
    assign ctrl.fire   = step_go;
    assign ctrl.uw     = uw;

endmodule

`default_nettype wire

/* rtl/core/osr_datapath.sv */
// Datapath of the refresh sequencer: configuration, panel and draw state,
// byte selection and the result register. Depends on osr_pkg.
`default_nettype none

module osr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire osr_pkg::osr_item_t  item,
    input  wire osr_pkg::seq_ctrl_t  ctrl,
    output osr_pkg::dp_status_t      st,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output osr_pkg::osr_result_t     result
);
    import osr_pkg::*;

    logic [15:0]       power_delay_reg, power_delay_next;
    logic [7:0]        wanted_face_reg, wanted_face_next;
    logic              got_request_reg, got_request_next;
    logic [7:0]        shown_face_reg,  shown_face_next;
    logic [PAGE_W-1:0] page_reg,        page_next;
    logic [COL_W-1:0]  col_reg,         col_next;
    logic              busy_reg,        busy_next;
    logic [INIT_W-1:0] init_step_reg,   init_step_next;
    logic              panel_ready_reg, panel_ready_next;
    logic [15:0]       settle_reg,      settle_next;
    logic [CNT_W-1:0]  cnt_reg,         cnt_next;
    logic [CNT_W-1:0]  beat_reg,        beat_next;
    logic              out_valid_reg,   out_valid_next;
    osr_result_t       result_reg,      result_next;

    logic [INIT_W-1:0] init_inc;
    logic [COL_W-1:0]  remaining;
    logic [COL_W:0]    col_inc;
    logic              last_page;
    logic              page_done;
    logic              chunk_end;
    logic              pixel_final;
    logic [7:0]        sel_byte;
    logic              sel_last;

    // Status decode
    assign init_inc    = init_step_reg + INIT_W'(1);
    assign remaining   = COL_W'(PANEL_COLUMNS) - col_reg;
    assign col_inc     = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign last_page   = (page_reg == PAGE_W'(PANEL_PAGES - 1));
    assign page_done   = (col_reg >= COL_W'(PANEL_COLUMNS));
    assign chunk_end   = (beat_reg == cnt_reg - CNT_W'(1));
    assign pixel_final = chunk_end && last_page
                         && (col_inc >= (COL_W + 1)'(PANEL_COLUMNS));

    assign st.panel_ready  = panel_ready_reg;
    assign st.settled      = (settle_reg >= power_delay_reg);
    assign st.init_nonzero = (init_step_reg != '0);
    assign st.draw_needed  = busy_reg || (shown_face_reg != wanted_face_reg);
    assign st.col_nonzero  = (col_reg != '0);
    assign st.chunk_end    = chunk_end;
    assign st.frame_end    = page_done && last_page;
    assign st.slot_free    = !out_valid_reg || result_ready;

    // Result byte select
    always_comb
    begin
        case (ctrl.uw.bsel)
            BYTE_CONST: sel_byte = ctrl.uw.konst;
            BYTE_INIT:  sel_byte = boot_cmd(init_step_reg);
            BYTE_PAGE:  sel_byte = CMD_PAGE + 8'(page_reg);
            BYTE_PIXEL: sel_byte = column_byte(shown_face_reg, col_reg, page_reg);
            default:    sel_byte = ctrl.uw.konst;
        endcase
    end

    // Final-result mark
    always_comb
    begin
        case (ctrl.uw.lsel)
            LAST_NO:    sel_last = 1'b0;
            LAST_YES:   sel_last = 1'b1;
            LAST_PIXEL: sel_last = chunk_end && !pixel_final;
            default:    sel_last = 1'b0;
        endcase
    end

    // State update
    always_comb
    begin
        power_delay_next = power_delay_reg;
        wanted_face_next = wanted_face_reg;
        got_request_next = got_request_reg;
        shown_face_next  = shown_face_reg;
        page_next        = page_reg;
        col_next         = col_reg;
        busy_next        = busy_reg;
        init_step_next   = init_step_reg;
        panel_ready_next = panel_ready_reg;
        settle_next      = settle_reg;
        cnt_next         = cnt_reg;
        beat_next        = beat_reg;
        out_valid_next   = out_valid_reg;
        result_next      = result_reg;

        // configuration writes
        if (cfg_we) begin
            if (cfg_index == CFG_POWER_DELAY) begin
                power_delay_next = cfg_data;
            end else if (!got_request_reg) begin
                wanted_face_next = cfg_data[7:0];
            end
        end

        // face requests and ticks act at once
        if (ctrl.accept) begin
            if (item.op == OP_REQUEST) begin
                wanted_face_next = item.face;
                got_request_next = 1'b1;
            end else if (item.op == OP_TICK && settle_reg != 16'hFFFF) begin
                settle_next = settle_reg + 16'd1;
            end
        end

        // program step actions
        if (ctrl.fire) begin
            case (ctrl.uw.act)
                ACT_NONE: ;
                ACT_INIT_ADV:
                begin
                    init_step_next = init_inc;
                    if ({1'b0, init_inc} >= (INIT_W + 1)'(INIT_LENGTH)) begin
                        panel_ready_next = 1'b1;
                    end
                end
                ACT_DRAW_START:
                begin
                    if (!busy_reg) begin
                        shown_face_next = wanted_face_reg;
                        page_next       = '0;
                        col_next        = '0;
                        busy_next       = 1'b1;
                    end
                end
                ACT_CHUNK_SETUP:
                begin
                    beat_next = '0;
                    if (remaining > COL_W'(COLUMNS_PER_CALL)) begin
                        cnt_next = CNT_W'(COLUMNS_PER_CALL);
                    end else begin
                        cnt_next = CNT_W'(remaining);
                    end
                end
                ACT_COL_ADV:
                begin
                    col_next  = col_reg + COL_W'(1);
                    beat_next = beat_reg + CNT_W'(1);
                end
                ACT_PAGE_ADV:
                begin
                    if (page_done) begin
                        col_next = '0;
                        if (last_page) begin
                            page_next = '0;
                            busy_next = 1'b0;
                        end else begin
                            page_next = page_reg + PAGE_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        // result register
        if (ctrl.fire && ctrl.uw.emit) begin
            out_valid_next           = 1'b1;
            result_next.kind         = ctrl.uw.kind;
            result_next.bus_byte     = sel_byte;
            result_next.start_before = ctrl.uw.start;
            result_next.stop_after   = ctrl.uw.stop
                                       || (ctrl.uw.bsel == BYTE_PIXEL && chunk_end);
            result_next.last         = sel_last;
        end else if (result_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            power_delay_reg <= POWER_DELAY_RESET;
            wanted_face_reg <= INITIAL_FACE_RESET;
            got_request_reg <= 1'b0;
            shown_face_reg  <= FACE_NONE;
            page_reg        <= '0;
            col_reg         <= '0;
            busy_reg        <= 1'b0;
            init_step_reg   <= '0;
            panel_ready_reg <= 1'b0;
            settle_reg      <= '0;
            cnt_reg         <= '0;
            beat_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            power_delay_reg <= power_delay_next;
            wanted_face_reg <= wanted_face_next;
            got_request_reg <= got_request_next;
            shown_face_reg  <= shown_face_next;
            page_reg        <= page_next;
            col_reg         <= col_next;
            busy_reg        <= busy_next;
            init_step_reg   <= init_step_next;
            panel_ready_reg <= panel_ready_next;
            settle_reg      <= settle_next;
            cnt_reg         <= cnt_next;
            beat_reg        <= beat_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // a result is only loaded into a free slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fire && ctrl.uw.emit |-> st.slot_free)
        else $error("result loaded over a pending result");

    // column position never runs past the panel edge
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(PANEL_COLUMNS))
        else $error("column position out of range");

    // drawing only starts after init is complete
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> panel_ready_reg)
        else $error("drawing while panel not ready");

    // a bus recovery result carries no byte and no start or stop mark
    a_recovery_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.kind |->
        result_reg.bus_byte == 8'h00 && !result_reg.start_before
        && !result_reg.stop_after)
        else $error("malformed bus recovery result");
`endif

endmodule

`default_nettype wire

/* tb/oled_sprite_refresh_sequencer_test.sv */
// Testbench for oled_sprite_refresh_sequencer: face requests, ticks and service
// calls go in, and each bus result is checked against an in-bench predictor.
// Depends on osr_pkg and the RTL of the block.
module oled_sprite_refresh_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import osr_pkg::*;

    localparam int         HALF_PERIOD  = 6;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PAUSE_CYCLES = 48;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         PHASE_ITEMS  = 40;

    // Panel set-up commands, one per init call
    localparam logic [7:0] PANEL_SETUP [24] = '{
        8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
        8'h8D, 8'h14, 8'h20, 8'h02, 8'hA1, 8'hC8, 8'hDA, 8'h12,
        8'h81, 8'h7F, 8'hD9, 8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6
    };

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_BOOT_FIRST,
        CHK_BOOT_SECOND
    } row_chk_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_act_t;

    // code is the op of a request or the index of a register write
    typedef struct {
        row_act_t    act;
        logic [1:0]  code;
        logic [15:0] value;
        int          reps;
        row_chk_t    chk;
    } script_row_t;

    // Directed part: delay boundary, init, first frames
    script_row_t script [22] = '{
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_NONE},
        '{ROW_ITEM, OP_UNUSED,            16'h00A5,  1, CHK_NONE},
        '{ROW_CFG,  2'(CFG_POWER_DELAY),  16'h0003,  1, CHK_MODEL},
        '{ROW_CFG,  2'(CFG_INITIAL_FACE), 16'h00FF,  1, CHK_MODEL},
        '{ROW_ITEM, OP_TICK,              16'h005A,  2, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_NONE},
        '{ROW_ITEM, OP_TICK,              16'h00FF,  1, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_BOOT_FIRST},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_BOOT_SECOND},
        '{ROW_ITEM, OP_SERVICE,           16'h0000, 22, CHK_MODEL},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_NONE},
        '{ROW_CFG,  2'(CFG_INITIAL_FACE), 16'h0005,  1, CHK_MODEL},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_MODEL},
        '{ROW_ITEM, OP_REQUEST,           16'h000C,  1, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000, 63, CHK_MODEL},
        '{ROW_ITEM, OP_UNUSED,            16'h005A,  1, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000, 64, CHK_MODEL},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  1, CHK_NONE},
        '{ROW_ITEM, OP_REQUEST,           16'h00FF,  1, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000,  9, CHK_MODEL},
        '{ROW_ITEM, OP_REQUEST,           16'h000B,  1, CHK_NONE},
        '{ROW_ITEM, OP_SERVICE,           16'h0000, 64, CHK_MODEL}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    osr_item_t   item         = '0;
    logic        result_ready = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [15:0] cfg_data     = '0;
    logic        item_ready;
    logic        result_valid;
    osr_result_t result;

    // Predicted panel state and registers
    logic [15:0] delay_ms    = POWER_DELAY_RESET;
    logic [7:0]  init_face   = INITIAL_FACE_RESET;
    logic [7:0]  want_face   = INITIAL_FACE_RESET;
    logic [7:0]  shown       = FACE_NONE;
    int          page_at     = 0;
    int          col_at      = 0;
    bit          drawing     = 1'b0;
    logic [4:0]  boot_step   = '0;
    bit          ready       = 1'b0;
    logic [15:0] settle      = '0;
    bit          got_request = 1'b0;

    osr_result_t call_bytes [$];
    osr_result_t bus_due [$];
    row_chk_t    row_check = CHK_MODEL;
    bit          calm      = 1'b0;
    int          failures  = 0;
    int          quiet     = 0;

    oled_sprite_refresh_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        result_ready <= calm || ($urandom_range(99) >= 14);
    end

    function automatic void put_byte(logic k, logic [7:0] b, logic st, logic sp);
        osr_result_t r;
        r = '{kind: k, bus_byte: b, start_before: st, stop_after: sp, last: 1'b0};
        call_bytes.push_back(r);
    endfunction

    function automatic void put_command(logic [7:0] c);
        put_byte(1'b0, BUS_ADDR, 1'b1, 1'b0);
        put_byte(1'b0, CTRL_CMD, 1'b0, 1'b0);
        put_byte(1'b0, c, 1'b0, 1'b1);
    endfunction

    // Column byte of a face: test pattern, centred 4x sprite, or blank
    function automatic logic [7:0] pixel_strip(logic [7:0] f, int x, int pg);
        int   bitpos;
        logic top;
        logic bot;
        if (f == 8'(TEST_FACE))
        begin
            if (x == 0 || x == PANEL_COLUMNS - 1)
                return 8'hFF;
            if (pg == 0)
                return 8'h01;
            if (pg == PANEL_PAGES - 1)
                return 8'h80;
            return x[3] ? 8'hAA : 8'h55;
        end
        if (f >= 8'(GLYPH_COUNT) || x < SPRITE_LEFT || x >= SPRITE_LEFT + SPRITE_W)
            return 8'h00;
        bitpos = 15 - (x - SPRITE_LEFT) / 4;
        top    = GLYPHS[f][2 * pg][bitpos];
        bot    = GLYPHS[f][2 * pg + 1][bitpos];
        return {{4{bot}}, {4{top}}};
    endfunction

    // Bus results of one request, left in call_bytes
    function automatic void predict_bus(osr_item_t it);
        int          cnt;
        osr_result_t tail;
        call_bytes.delete();
        if (it.op == OP_REQUEST)
        begin
            want_face   = it.face;
            got_request = 1'b1;
        end
        else if (it.op == OP_TICK)
        begin
            if (settle != 16'hFFFF)
                settle++;
        end
        else if (it.op == OP_SERVICE)
        begin
            if (!ready)
            begin
                // init: bus recovery first, then one command per call
                if (settle >= delay_ms)
                begin
                    if (boot_step == 0)
                        put_byte(1'b1, 8'h00, 1'b0, 1'b0);
                    put_command(boot_step < $size(PANEL_SETUP) ?
                                PANEL_SETUP[boot_step] : CMD_NOP);
                    boot_step = boot_step + 5'd1;
                    if (boot_step >= INIT_LENGTH)
                        ready = 1'b1;
                end
            end
            else if (drawing || shown != want_face)
            begin
                if (!drawing)
                begin
                    shown   = want_face;
                    page_at = 0;
                    col_at  = 0;
                    drawing = 1'b1;
                end
                if (col_at == 0)
                begin
                    put_command(8'(CMD_PAGE + page_at));
                    put_command(CMD_COL_LO);
                    put_command(CMD_COL_HI);
                end
                cnt = PANEL_COLUMNS - col_at;
                if (cnt > COLUMNS_PER_CALL)
                    cnt = COLUMNS_PER_CALL;
                put_byte(1'b0, BUS_ADDR, 1'b1, 1'b0);
                put_byte(1'b0, CTRL_DATA, 1'b0, cnt == 0);
                for (int i = 0; i < cnt; i++)
                begin
                    put_byte(1'b0, pixel_strip(shown, col_at, page_at), 1'b0, i + 1 == cnt);
                    col_at++;
                end
                if (col_at >= PANEL_COLUMNS)
                begin
                    col_at = 0;
                    page_at++;
                    if (page_at >= PANEL_PAGES)
                    begin
                        page_at = 0;
                        drawing = 1'b0;
                        put_command(CMD_ON);
                    end
                end
            end
        end
        if (call_bytes.size() != 0)
        begin
            tail      = call_bytes[call_bytes.size() - 1];
            tail.last = 1'b1;
            call_bytes[call_bytes.size() - 1] = tail;
        end
    endfunction

    // Results typed in for the directed rows that read off at a glance
    function automatic void queue_typed(row_chk_t c);
        if (c == CHK_BOOT_FIRST)
            bus_due.push_back(osr_result_t'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0});
        if (c == CHK_BOOT_FIRST || c == CHK_BOOT_SECOND)
        begin
            bus_due.push_back(osr_result_t'{1'b0, BUS_ADDR, 1'b1, 1'b0, 1'b0});
            bus_due.push_back(osr_result_t'{1'b0, CTRL_CMD, 1'b0, 1'b0, 1'b0});
        end
        if (c == CHK_BOOT_FIRST)
            bus_due.push_back(osr_result_t'{1'b0, 8'hAE, 1'b0, 1'b1, 1'b1});
        if (c == CHK_BOOT_SECOND)
            bus_due.push_back(osr_result_t'{1'b0, 8'hD5, 1'b0, 1'b1, 1'b1});
    endfunction

    function automatic void check_field(string name, int e, int a);
        if (e != a)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
        end
    endfunction

    // Acceptance monitor, scoreboard and stall watchdog
    always @(posedge clk)
    begin
        osr_result_t due;
        bit          took;
        if (rst_n)
        begin
            took = 1'b0;
            if (item_valid && item_ready)
            begin
                took = 1'b1;
                predict_bus(item);
                if (row_check == CHK_MODEL)
                begin
                    foreach (call_bytes[i])
                        bus_due.push_back(call_bytes[i]);
                end
                else
                    queue_typed(row_check);
            end
            if (result_valid && result_ready)
            begin
                took = 1'b1;
                if (bus_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, result);
                end
                else
                begin
                    due = bus_due.pop_front();
                    check_field("kind", due.kind, result.kind);
                    check_field("bus_byte", due.bus_byte, result.bus_byte);
                    check_field("start_before", due.start_before, result.start_before);
                    check_field("stop_after", due.stop_after, result.stop_after);
                    check_field("last", due.last, result.last);
                end
            end
            quiet = took ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // One request; entered and left on a falling edge
    task automatic push_item(osr_item_t it, row_chk_t c);
        if (!calm && $urandom_range(99) < 14)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        row_check = c;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    // Let every due result drain and the block go idle
    task automatic settle_down();
        item_valid <= 1'b0;
        while (bus_due.size() != 0)
            @(negedge clk);
        repeat (PAUSE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_POWER_DELAY)
            delay_ms = v;
        else
        begin
            init_face = v[7:0];
            if (!got_request)
                want_face = init_face;
        end
    endtask

    // Mostly service calls so frames complete; requests favour real faces
    function automatic osr_item_t random_item();
        osr_item_t it;
        int        pick;
        pick    = $urandom_range(99);
        it.face = 8'($urandom);
        if (pick < 66)
            it.op = OP_SERVICE;
        else if (pick < 80)
            it.op = OP_TICK;
        else if (pick < 85)
            it.op = OP_UNUSED;
        else
        begin
            it.op = OP_REQUEST;
            case ($urandom_range(9))
                0, 1, 2, 3: it.face = 8'($urandom_range(GLYPH_COUNT - 1));
                4, 5:       it.face = 8'(TEST_FACE);
                6:          it.face = FACE_NONE;
                7:          it.face = shown;
                default:    ;
            endcase
        end
        return it;
    endfunction

    initial
    begin
        osr_item_t it;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (script[r])
        begin
            if (script[r].act == ROW_CFG)
            begin
                settle_down();
                write_register(script[r].code[0], script[r].value);
            end
            else
            begin
                it.op   = script[r].code;
                it.face = script[r].value[7:0];
                repeat (script[r].reps) push_item(it, script[r].chk);
            end
        end

        // Random phases, each under a different register setting
        for (int ph = 0; ph < 3; ph++)
        begin
            settle_down();
            if (ph == 0)
            begin
                write_register(CFG_POWER_DELAY, 16'h0000);
                write_register(CFG_INITIAL_FACE, 16'h0000);
            end
            else if (ph == 1)
            begin
                write_register(CFG_POWER_DELAY, 16'($urandom_range(65535)));
                write_register(CFG_INITIAL_FACE, 16'h00FF);
            end
            else
            begin
                write_register(CFG_POWER_DELAY, 16'hFFFF);
                write_register(CFG_INITIAL_FACE, 16'($urandom_range(255)));
            end
            calm = (ph == 1);
            repeat (PHASE_ITEMS) push_item(random_item(), CHK_MODEL);
        end
        calm = 1'b0;
        settle_down();

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/osr_pkg.sv
rtl/core/osr_ucode_rom.sv
rtl/core/osr_sequencer.sv
rtl/core/osr_datapath.sv
rtl/core/oled_sprite_refresh_sequencer.sv
tb/oled_sprite_refresh_sequencer_test.sv
